// ===== hdl/modular_power_inverse_divide_macros.svh =====
// Assertion macros shared by the modular power, inverse and divide block.
`ifndef MODULAR_POWER_INVERSE_DIVIDE_MACROS_SVH
`define MODULAR_POWER_INVERSE_DIVIDE_MACROS_SVH

// same-cycle implication
`define PMID_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmid assertion failed");

// next-cycle implication
`define PMID_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmid assertion failed");

`endif

// ===== hdl/pmid_pkg.sv =====
// Types and constants of the modular power, inverse and divide block.
package pmid_pkg;

   localparam logic [1:0] FUNC_POW = 2'd0;
   localparam logic [1:0] FUNC_INV = 2'd1;
   localparam logic [1:0] FUNC_DIV = 2'd2;

   localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
   localparam logic        CSR_MODULUS   = 1'b0;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ===== hdl/pmid_mul.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle over the 32-bit multiplier.
module pmid_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              x,
   input  logic [31:0]              y,
   input  logic [31:0]              m,
   output logic [31:0]              prod,
   output pmid_pkg::unit_status_type status
);
   import pmid_pkg::*;

   logic [31:0] acc_ff, acc_in, x_ff, y_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] dbl, dbl_red, sum, sum_red;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      sum     = dbl_red + (y_ff[31] ? {1'b0, x_ff} : 33'd0);
      sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
      acc_in  = sum_red[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         x_ff   <= x;
         y_ff   <= y;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         y_ff   <= {y_ff[30:0], 1'b0};
      end
   end

   assign prod   = acc_ff;
   assign status = '{busy: busy_ff, done: done_ff};

endmodule

// ===== hdl/pmid_reduce.sv =====
// Bit-serial reduction of a 64-bit operand modulo the modulus.
module pmid_reduce (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [63:0]              value,
   input  logic [31:0]              m,
   output logic [31:0]              residue,
   output pmid_pkg::unit_status_type status
);
   import pmid_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [63:0] val_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [32:0] t;

   always_comb begin
      t      = {rem_ff, val_ff[63]};
      rem_in = (t >= {1'b0, m}) ? 32'(t - {1'b0, m}) : t[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         val_ff <= value;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         val_ff <= {val_ff[62:0], 1'b0};
      end
   end

   assign residue = rem_ff;
   assign status  = '{busy: busy_ff, done: done_ff};

endmodule

// ===== hdl/modular_power_inverse_divide.sv =====
// Top level: sequencer for modular power, inverse and divide.
// Sequence: operand reduction, then one square-and-multiply step per exponent bit
// (EXP_BITS bits for power, 32 for inverse and divide), plus a final multiply for divide.
// One transaction at a time: the next is accepted the cycle after the result is taken.
//   Throughput is set by the bit-serial reducers and multipliers and by rsp_ready.
// Synchronous active-high reset clears control state and sets the modulus.
`include "modular_power_inverse_divide_macros.svh"
module modular_power_inverse_divide #(
   parameter int EXP_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   input  logic [63:0] req_exponent,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pmid_pkg::*;

   localparam int EW = (EXP_BITS > 32) ? EXP_BITS : 32;
   localparam int CW = $clog2(EW + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_POW    = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]    state_ff;
   logic [31:0]   mod_ff;
   logic [1:0]    func_ff;
   logic [EW-1:0] exp_ff;
   logic [CW-1:0] cnt_ff, nbits_ff;
   logic [31:0]   r_ff, base_ff, res_ff, r_in;
   logic          mstart_ff;
   logic          req_fire, csr_wr;

   logic [31:0]     red_a, red_b, prod_rb, prod_bb;
   unit_status_type st_ra, st_rb, st_m1, st_m2;

   assign pready    = 1'b1;
   assign csr_wr    = psel & penable & pwrite;
   assign prdata    = (paddr[2] == CSR_MODULUS) ? mod_ff : 32'd0;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_result = res_ff;
   assign r_in = exp_ff[0] ? prod_rb : r_ff;

   pmid_reduce u_red_a (
      .clock(clock), .reset(reset), .start(req_fire), .value(req_operand_a),
      .m(mod_ff), .residue(red_a), .status(st_ra)
   );
   pmid_reduce u_red_b (
      .clock(clock), .reset(reset), .start(req_fire), .value(req_operand_b),
      .m(mod_ff), .residue(red_b), .status(st_rb)
   );
   pmid_mul u_mul_rb (
      .clock(clock), .reset(reset), .start(mstart_ff), .x(r_ff), .y(base_ff),
      .m(mod_ff), .prod(prod_rb), .status(st_m1)
   );
   pmid_mul u_mul_bb (
      .clock(clock), .reset(reset), .start(mstart_ff), .x(base_ff), .y(base_ff),
      .m(mod_ff), .prod(prod_bb), .status(st_m2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET;
      end else if (csr_wr && paddr[2] == CSR_MODULUS) begin
         mod_ff <= pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mstart_ff <= 1'b0;
      end else begin
         mstart_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  func_ff  <= req_func;
                  exp_ff   <= EW'(req_exponent[EXP_BITS-1:0]);
                  state_ff <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               if (st_ra.done && st_rb.done) begin
                  if (mod_ff < 32'd2 || !(func_ff == FUNC_POW || func_ff == FUNC_INV
                        || func_ff == FUNC_DIV)) begin
                     res_ff   <= '0;
                     state_ff <= ST_DONE;
                  end else begin
                     base_ff <= (func_ff == FUNC_DIV) ? red_b : red_a;
                     if (func_ff != FUNC_POW) begin
                        exp_ff   <= EW'(mod_ff - 32'd2);
                        nbits_ff <= CW'(32);
                     end else begin
                        nbits_ff <= CW'(EXP_BITS);
                     end
                     r_ff      <= 32'd1;
                     cnt_ff    <= '0;
                     mstart_ff <= 1'b1;
                     state_ff  <= ST_POW;
                  end
               end
            end
            ST_POW: begin
               if (st_m1.done && st_m2.done) begin
                  exp_ff <= exp_ff >> 1;
                  cnt_ff <= cnt_ff + CW'(1);
                  if (cnt_ff == nbits_ff - CW'(1)) begin
                     if (func_ff == FUNC_DIV) begin
                        r_ff      <= r_in;
                        base_ff   <= red_a;
                        mstart_ff <= 1'b1;
                        state_ff  <= ST_MUL;
                     end else begin
                        res_ff   <= r_in;
                        state_ff <= ST_DONE;
                     end
                  end else begin
                     r_ff      <= r_in;
                     base_ff   <= prod_bb;
                     mstart_ff <= 1'b1;
                  end
               end
            end
            ST_MUL: begin
               if (st_m1.done) begin
                  res_ff   <= prod_rb;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `PMID_ASSERT_NXT(a_accept_reduce, clock, reset, req_fire, state_ff == ST_REDUCE)
   `PMID_ASSERT_IMP(a_red_in_range, clock, reset, st_ra.done && mod_ff >= 32'd2, red_a < mod_ff)
   `PMID_ASSERT_IMP(a_cnt_bound, clock, reset, state_ff == ST_POW, cnt_ff < nbits_ff)
   `PMID_ASSERT_IMP(a_mul_in_range, clock, reset, st_m1.done && state_ff == ST_POW,
      prod_rb < mod_ff)

endmodule

// ===== bench/modular_power_inverse_divide_tb.sv =====
// Testbench for modular_power_inverse_divide: random and directed modular arithmetic checks.
`timescale 1ns / 1ps
module modular_power_inverse_divide_tb;
   import pmid_pkg::*;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int N_MODULI = 10;

   typedef struct {
      logic [1:0]  func;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] e;
   } arith_req_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic [63:0] req_exponent;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_result;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   arith_req_type  pending_reqs[$];
   logic [31:0]    expected_residues[$];
   logic [31:0]    cur_modulus;
   bit             req_fired;
   int             gap_left;
   int             burst_left;
   int             stall_hold;
   bit             long_hold_done;
   int             stall_mode;
   int             accepted_cnt;
   int             result_cnt;
   int             mismatches;
   int             func_cnt[4];

   modular_power_inverse_divide i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result(rsp_result),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
                                               int nbits, longint unsigned m);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % m;
      sq  = base % m;
      for (int i = 0; i < nbits; i++) begin
         if (ex[i])
            acc = (acc * sq) % m;
         sq = (sq * sq) % m;
      end
      return acc;
   endfunction

   function automatic logic [31:0] residue_of(arith_req_type r, logic [31:0] modulus);
      longint unsigned m;
      longint unsigned a;
      longint unsigned b;
      m = modulus;
      if (m < 2)
         return 32'd0;
      a = r.a % m;
      b = r.b % m;
      case (r.func)
         FUNC_POW: return 32'(pow_mod(a, r.e, 64, m));
         FUNC_INV: return 32'(pow_mod(a, m - 2, 32, m));
         FUNC_DIV: return 32'((a * pow_mod(b, m - 2, 32, m)) % m);
         default:  return 32'd0;
      endcase
   endfunction

   function automatic logic [63:0] pick_operand(logic [31:0] modulus);
      logic [63:0] v;
      case ($urandom_range(0, 4))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 7));
         2: v = 64'(modulus) * $urandom + $urandom_range(0, 2);
         3: v = ~64'($urandom_range(0, 3));
         default: v = 64'($urandom);
      endcase
      return v;
   endfunction

   function automatic arith_req_type random_req(logic [31:0] modulus);
      arith_req_type r;
      r.func = ($urandom_range(0, 19) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
      r.a = pick_operand(modulus);
      r.b = pick_operand(modulus);
      case ($urandom_range(0, 3))
         0: r.e = 64'($urandom_range(0, 3));
         1: r.e = 64'(modulus) - 64'($urandom_range(0, 2));
         default: r.e = {$urandom, $urandom};
      endcase
      return r;
   endfunction

   function automatic arith_req_type mk(logic [1:0] f, logic [63:0] a, logic [63:0] b,
                                        logic [63:0] e);
      arith_req_type r;
      r.func = f; r.a = a; r.b = b; r.e = e;
      return r;
   endfunction

   function automatic void add_req(arith_req_type r);
      pending_reqs = {pending_reqs, r};
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // sender: bursts and gaps
   always @(negedge clock) begin
      arith_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
         req_func <= '0; req_operand_a <= '0; req_operand_b <= '0; req_exponent <= '0;
         gap_left = 0;
         burst_left = 1;
      end else if (req_valid && !req_fired) begin
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (pending_reqs.size() > 0) begin
         r = pending_reqs.pop_front();
         req_func <= r.func; req_operand_a <= r.a; req_operand_b <= r.b; req_exponent <= r.e;
         req_valid <= 1'b1;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 6);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3000);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: own stall pattern, one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_hold = 0;
         long_hold_done = 0;
         stall_mode = 0;
      end else if (stall_hold > 0) begin
         rsp_ready <= 1'b0;
         stall_hold--;
      end else if (!long_hold_done && accepted_cnt >= 40) begin
         long_hold_done = 1;
         stall_hold = 12000;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 499) == 0)
            stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_ready <= 1'b1;
               stall_hold = $urandom_range(1, 40);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      arith_req_type r;
      logic [31:0] want;
      req_fired = 0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            r.func = req_func; r.a = req_operand_a; r.b = req_operand_b; r.e = req_exponent;
            expected_residues = {expected_residues, residue_of(r, cur_modulus)};
            func_cnt[req_func]++;
            accepted_cnt++;
            req_fired = 1;
         end
         if (rsp_valid && rsp_ready) begin
            result_cnt++;
            if (expected_residues.size() == 0) begin
               $error("unexpected transaction: result %0d", rsp_result);
               mismatches++;
            end else begin
               want = expected_residues.pop_front();
               if (rsp_result !== want) begin
                  $error("result: expected %0d, actual %0d", want, rsp_result);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic write_modulus(logic [31:0] value);
      @(negedge clock);
      psel = 1; pwrite = 1; penable = 0;
      paddr = {CSR_MODULUS, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      cur_modulus = value;
      @(negedge clock);
      pwrite = 0; penable = 0;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      if (prdata !== value) begin
         $error("modulus readback: expected %0d, actual %0d", value, prdata);
         mismatches++;
      end
      @(negedge clock);
      psel = 0; penable = 0;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_residues.size() > 0 || req_valid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [31:0] moduli[N_MODULI];
      int          counts[N_MODULI];
      logic [31:0] m;
      moduli = '{MODULUS_RESET, 32'd2, 32'd4294967291, 32'd4294967295, 32'd0,
                 32'd1, 32'd65537, 32'd3, 32'd91, MODULUS_RESET};
      counts = '{160, 30, 160, 60, 15, 15, 100, 30, 30, 40};
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      cur_modulus = MODULUS_RESET;
      accepted_cnt = 0; result_cnt = 0; mismatches = 0;
      func_cnt = '{0, 0, 0, 0};
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset value in effect before any write
      add_req(mk(FUNC_INV, 64'd2, 64'd0, 64'd0));
      add_req(mk(FUNC_POW, 64'd3, 64'd0, 64'd1000));
      drain();

      for (int p = 0; p < N_MODULI; p++) begin
         m = moduli[p];
         write_modulus(m);
         if (p == 0) begin
            add_req(mk(FUNC_POW, 64'd0, 64'd0, 64'd0));
            add_req(mk(FUNC_POW, 64'd5, 64'd0, 64'd0));
            add_req(mk(FUNC_POW, '1, '1, '1));
            add_req(mk(FUNC_POW, 64'd2, 64'd0, 64'd1));
            add_req(mk(FUNC_POW, 64'd7, 64'd0, 64'h8000_0000_0000_0000));
            add_req(mk(FUNC_POW, 64'(m) - 1, 64'd0, 64'd2));
            add_req(mk(FUNC_INV, 64'd0, 64'd9, 64'd9));
            add_req(mk(FUNC_INV, '1, '0, '1));
            add_req(mk(FUNC_INV, 64'(m), 64'd0, 64'd0));
            add_req(mk(FUNC_DIV, 64'd10, 64'd0, 64'd0));
            add_req(mk(FUNC_DIV, 64'd10, 64'(m) * 3, 64'd0));
            add_req(mk(FUNC_DIV, 64'd10, 64'd4, 64'd0));
            add_req(mk(FUNC_DIV, '1, '1, '0));
            add_req(mk(FUNC_NONE, 64'd5, 64'd6, 64'd7));
            add_req(mk(FUNC_NONE, '1, '1, '1));
         end
         for (int i = 0; i < counts[p]; i++)
            add_req(random_req(m));
         drain();
      end

      repeat (2500) @(posedge clock);
      $display("Covered %0d transactions over %0d moduli: power %0d, inverse %0d,",
               result_cnt, N_MODULI, func_cnt[0], func_cnt[1]);
      $display("divide %0d, unused selector %0d; %0d mismatches.",
               func_cnt[2], func_cnt[3], mismatches);
      if (mismatches == 0 && expected_residues.size() == 0)
         $display("PASS modular_power_inverse_divide");
      else
         $display("FAIL modular_power_inverse_divide");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("FAIL modular_power_inverse_divide");
      $finish;
   end

endmodule

// ===== modular_power_inverse_divide.f =====
+incdir+hdl
hdl/pmid_pkg.sv
hdl/pmid_mul.sv
hdl/pmid_reduce.sv
hdl/modular_power_inverse_divide.sv
bench/modular_power_inverse_divide_tb.sv
